// ===== sv/ring_buffer_fifo_lifo_peek_macros.svh =====
// Assertion macros for the ring buffer checker.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef RING_BUFFER_FIFO_LIFO_PEEK_MACROS_SVH
`define RING_BUFFER_FIFO_LIFO_PEEK_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RBFL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RBFL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rbfl_pkg.sv =====
// Package for the ring buffer: sizes, command codes and controller commands.
// No dependencies.
`timescale 1ns / 1ps

package rbfl_pkg;

    localparam int DEPTH      = 256;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CMD_W      = 3;
    localparam int POS_W      = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE    = 3'd0,
        CMD_POP_OLD  = 3'd1,
        CMD_POP_NEW  = 3'd2,
        CMD_PEEK_OLD = 3'd3,
        CMD_PEEK_NEW = 3'd4
    } t_cmd;

    typedef struct packed {
        logic accept;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic rd_ok;
    } t_dp_stat;

endpackage

// ===== sv/rbfl_ifs.sv =====
// Channel interfaces for the ring buffer: command in, result out, capacity write.
// Depends on rbfl_pkg.
`timescale 1ns / 1ps

interface rbfl_in_if;
    import rbfl_pkg::*;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [DATA_WIDTH-1:0] data_in;
    logic [POS_W-1:0]  position;
    modport source (output valid, cmd, data_in, position, input ready);
    modport sink (input valid, cmd, data_in, position, output ready);
endinterface

interface rbfl_out_if;
    import rbfl_pkg::*;
    logic              valid;
    logic              ready;
    logic [DATA_WIDTH-1:0] value;
    logic              ok;
    logic [CNT_W-1:0]  used_count;
    logic [CNT_W-1:0]  free_count;
    logic              full_res;
    modport source (output valid, value, ok, used_count, free_count, full_res, input ready);
    modport sink (input valid, value, ok, used_count, free_count, full_res, output ready);
endinterface

interface rbfl_cfg_if;
    import rbfl_pkg::*;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== sv/rbfl_ctrl.sv =====
// Controller for the ring buffer: accept, wait for the memory read, load result.
// Depends on rbfl_pkg.
`timescale 1ns / 1ps

module rbfl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  rbfl_pkg::t_dp_stat i_stat,
    output rbfl_pkg::t_dp_cmd o_cmd
);
    import rbfl_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DONE = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.load = i_stat.rd_ok && (!r_out_valid || i_out_ready);
                if (o_cmd.load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== sv/rbfl_dp.sv =====
// Datapath for the ring buffer: pointers, count, capacity, element memory, result.
// Depends on rbfl_pkg.
`timescale 1ns / 1ps

module rbfl_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rbfl_pkg::t_dp_cmd             i_cmd,
    output rbfl_pkg::t_dp_stat            o_stat,
    input  logic [rbfl_pkg::CMD_W-1:0]    i_cmd_code,
    input  logic [rbfl_pkg::DATA_WIDTH-1:0] i_data_in,
    input  logic [rbfl_pkg::POS_W-1:0]    i_position,
    input  logic                          i_cfg_write,
    input  logic [rbfl_pkg::CNT_W-1:0]    i_cfg_data,
    output logic [rbfl_pkg::DATA_WIDTH-1:0] o_value,
    output logic                          o_ok,
    output logic [rbfl_pkg::CNT_W-1:0]    o_used_count,
    output logic [rbfl_pkg::CNT_W-1:0]    o_free_count,
    output logic                          o_full_res
);
    import rbfl_pkg::*;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    logic [CNT_W-1:0]  r_capacity, n_capacity;
    logic [ADDR_W-1:0] r_newest, n_newest;
    logic [ADDR_W-1:0] r_write, n_write;
    logic [CNT_W-1:0]  r_held, n_held;

    logic              r_sel, n_sel;
    logic              r_ok, n_ok;
    logic [CNT_W-1:0]  r_used, r_free;
    logic              r_full;
    logic              r_pend;

    logic [CNT_W-1:0]  back;
    logic [CNT_W-1:0]  newest_ext;
    logic [CNT_W:0]    slot_sum;
    logic [ADDR_W-1:0] slot;
    logic [ADDR_W-1:0] addr;
    logic              pos_hit;
    logic              is_write;
    logic [CNT_W-1:0]  wr_next;
    logic [CNT_W-1:0]  cfg_cap;

    assign newest_ext = {1'b0, r_newest};
    assign pos_hit    = {1'b0, i_position} < r_held;
    assign wr_next    = {1'b0, r_write} + CNT_W'(1);

    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_cap = CNT_W'(1);
        end else if (i_cfg_data > CNT_W'(DEPTH)) begin
            cfg_cap = CNT_W'(DEPTH);
        end else begin
            cfg_cap = i_cfg_data;
        end
    end

    always_comb begin
        back       = '0;
        n_ok       = 1'b0;
        n_sel      = 1'b0;
        is_write   = 1'b0;
        n_newest   = r_newest;
        n_write    = r_write;
        n_held     = r_held;
        n_capacity = r_capacity;
        slot_sum   = '0;
        unique case (t_cmd'(i_cmd_code))
            CMD_POP_OLD:  back = r_held - CNT_W'(1);
            CMD_PEEK_OLD: back = r_held - CNT_W'(1) - {1'b0, i_position};
            CMD_PEEK_NEW: back = {1'b0, i_position};
            CMD_POP_NEW:  back = (r_capacity == CNT_W'(1)) ? '0 : CNT_W'(1);
            default:      back = '0;
        endcase
        if (newest_ext >= back) begin
            slot_sum = {1'b0, newest_ext - back};
        end else begin
            slot_sum = {1'b0, newest_ext} + {1'b0, r_capacity} - {1'b0, back};
        end
        slot = slot_sum[ADDR_W-1:0];
        addr = slot;

        unique case (t_cmd'(i_cmd_code))
            CMD_WRITE: begin
                is_write = 1'b1;
                n_ok     = 1'b1;
                addr     = r_write;
                n_newest = r_write;
                n_write  = (wr_next == r_capacity) ? '0 : wr_next[ADDR_W-1:0];
                if (r_held < r_capacity) begin
                    n_held = r_held + CNT_W'(1);
                end
            end
            CMD_POP_OLD: begin
                n_ok = r_held != '0;
                if (n_ok) begin
                    n_held = r_held - CNT_W'(1);
                end
            end
            CMD_POP_NEW: begin
                n_ok = r_held != '0;
                addr = r_newest;
                if (n_ok) begin
                    n_write  = r_newest;
                    n_newest = slot;
                    n_held   = r_held - CNT_W'(1);
                end
            end
            CMD_PEEK_OLD, CMD_PEEK_NEW: begin
                n_ok = pos_hit;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
        n_sel = n_ok && !is_write;

        if (i_cfg_write) begin
            n_capacity = cfg_cap;
            n_newest   = '0;
            n_write    = '0;
            n_held     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && is_write) begin
            r_mem[addr] <= i_data_in;
        end
        if (i_cmd.accept) begin
            r_rd_data <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CNT_W'(DEPTH);
            r_newest   <= '0;
            r_write    <= '0;
            r_held     <= '0;
            r_pend     <= 1'b0;
        end else begin
            if (i_cfg_write || i_cmd.accept) begin
                r_capacity <= n_capacity;
                r_newest   <= n_newest;
                r_write    <= n_write;
                r_held     <= n_held;
            end
            if (i_cmd.accept) begin
                r_pend <= 1'b1;
            end else if (i_cmd.load) begin
                r_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sel  <= n_sel;
            r_ok   <= n_ok;
            r_used <= n_held;
            r_free <= r_capacity - n_held;
            r_full <= n_held == r_capacity;
        end
        if (i_cmd.load) begin
            o_value      <= r_sel ? r_rd_data : '0;
            o_ok         <= r_ok;
            o_used_count <= r_used;
            o_free_count <= r_free;
            o_full_res   <= r_full;
        end
    end

    assign o_stat.rd_ok = r_pend;

endmodule

// ===== sv/ring_buffer_fifo_lifo_peek.sv =====
// Overwriting circular buffer usable as FIFO and stack, with peek by offset.
// Channels: i_in carries one command item (cmd, data_in, position) per
// valid/ready handshake; o_out returns exactly one result item per command
// (value, ok, used_count, free_count, full_res). i_cfg writes the capacity,
// 0 acting as 1 and values above 256 as 256; a write empties the buffer and
// is always ready. Write it only while no command is in flight.
// Each accepted command registers its element memory read; its result is then
// loaded into the output register when o_out is free. The next command is
// accepted only once that result has been loaded into the output register.
// i_in.ready is low in the cycle after each accept.
// Reset empties the buffer and sets capacity to 256; memory contents are not
// cleared. When the receiver stalls, the result waits in the output register;
// the next command is accepted meanwhile and its result is held inside until
// o_out is taken.
// Depends on rbfl_pkg, rbfl_ifs, rbfl_ctrl and rbfl_dp.
`timescale 1ns / 1ps

module ring_buffer_fifo_lifo_peek (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rbfl_in_if.sink     i_in,
    rbfl_out_if.source  o_out,
    rbfl_cfg_if.sink    i_cfg
);
    import rbfl_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    assign i_cfg.ready = 1'b1;

    rbfl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    rbfl_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_cmd_code   (i_in.cmd),
        .i_data_in    (i_in.data_in),
        .i_position   (i_in.position),
        .i_cfg_write  (i_cfg.valid),
        .i_cfg_data   (i_cfg.data),
        .o_value      (o_out.value),
        .o_ok         (o_out.ok),
        .o_used_count (o_out.used_count),
        .o_free_count (o_out.free_count),
        .o_full_res   (o_out.full_res)
    );

endmodule

// ===== sv/rbfl_chk.sv =====
// Port checker for the ring buffer, bound to the top level.
// Depends on rbfl_pkg and ring_buffer_fifo_lifo_peek_macros.svh.
`timescale 1ns / 1ps
`include "ring_buffer_fifo_lifo_peek_macros.svh"

module rbfl_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [rbfl_pkg::DATA_WIDTH-1:0] i_value,
    input logic                            i_ok,
    input logic [rbfl_pkg::CNT_W-1:0]      i_used_count,
    input logic [rbfl_pkg::CNT_W-1:0]      i_free_count,
    input logic                            i_full_res
);
    import rbfl_pkg::*;

    `RBFL_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_value), "result dropped or changed while stalled")
    `RBFL_ASSERT_NEXT(a_one_in_flight, i_in_valid && i_in_ready, !i_in_ready, "command accepted while another is in flight")
    `RBFL_ASSERT_NOW(a_fail_zero, i_out_valid && !i_ok, i_value == '0, "failed command returned a nonzero value")
    `RBFL_ASSERT_NOW(a_full_free, i_out_valid, i_full_res == (i_free_count == '0) && (i_used_count + i_free_count) <= CNT_W'(DEPTH), "full flag or counts inconsistent")

endmodule

bind ring_buffer_fifo_lifo_peek rbfl_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_value      (o_out.value),
    .i_ok         (o_out.ok),
    .i_used_count (o_out.used_count),
    .i_free_count (o_out.free_count),
    .i_full_res   (o_out.full_res)
);
